FILE: rtl/spdc_pkg.sv
// ----------------------------------------------------------------------------
// spdc_pkg: shared types and constants
// Holds the sequencer states, the window command word and the fixed constants
// of the speed controller.
// ----------------------------------------------------------------------------
package spdc_pkg;

  localparam int unsigned NUM_W = 30;
  localparam int unsigned DEN_W = 20;

  localparam logic [23:0] SPEED_MAX  = 24'hFFFFFF;
  localparam logic [28:0] SPEED_NUM  = 29'd320000000;
  localparam logic [14:0] DUTY_FULL  = 15'd25600;
  localparam logic [14:0] DUTY_HALF  = 15'd12800;
  localparam logic [14:0] DUTY_ZERO  = 15'd0;
  localparam logic signed [26:0] INT_LIMIT = 27'sd10240000;
  localparam logic [10:0] KP_GAIN    = 11'd1375;
  localparam logic [17:0] U_HALF     = 18'd160000;
  localparam logic [37:0] U_MAG_LIM  = 38'd33554431;
  localparam logic [6:0]  TGT_LOW    = 7'd10;
  localparam logic [6:0]  TGT_HIGH   = 7'd50;

  // Reciprocals for the fixed divisors. The control divisor 320000 is split
  // into a shift by 9 and a division by 625 (ceil(2^27/625)); the duty
  // divisor 158 uses ceil(2^30/158). Both are exact over their operand ranges.
  localparam logic [17:0] U_RCP      = 18'd214749;
  localparam logic [22:0] DUTY_RCP   = 23'd6795835;

  localparam logic [1:0] REG_TARGET  = 2'd0;
  localparam logic [1:0] REG_REVERSE = 2'd1;
  localparam logic [1:0] REG_HOLD    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPD, ST_SUM, ST_AVG, ST_ERR, ST_UST, ST_UQ, ST_DNUM, ST_DSCL, ST_FIN
  } spdc_state_t;

  typedef struct packed {
    logic rd;
    logic upd;
  } spdc_win_cmd_t;

endpackage

FILE: rtl/spdc_div.sv
// ----------------------------------------------------------------------------
// spdc_div: restoring divider
// Unsigned division, one quotient bit per cycle, with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module spdc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [spdc_pkg::NUM_W-1:0] num,
  input  logic [spdc_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [spdc_pkg::NUM_W-1:0] quo
);
  import spdc_pkg::*;

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    trial    = {rem_r, q_r[NUM_W-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = num;
      rem_nxt = '0;
      cnt_nxt = 5'(NUM_W);
    end else if (cnt_r != 5'd0) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

FILE: rtl/spdc_window.sv
// ----------------------------------------------------------------------------
// spdc_window: speed history memory and running sum
// A circular buffer in a synchronous memory; the oldest entry is read, then
// overwritten by the new speed while the running sum is corrected.
// ----------------------------------------------------------------------------
module spdc_window #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spdc_pkg::spdc_win_cmd_t    cmd,
  input  logic [23:0]                speed,
  output logic [spdc_pkg::NUM_W-1:0] sum
);
  import spdc_pkg::*;

  localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned SW = 24 + ((WINDOW > 1) ? $clog2(WINDOW) : 0);

  logic [23:0]   mem [WINDOW];
  logic [23:0]   rd_data_r;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic          full;

  assign full = (cnt_r == CW'(WINDOW));

  always_comb begin
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (cmd.upd) begin
      ptr_nxt = (ptr_r == PW'(WINDOW - 1)) ? '0 : ptr_r + PW'(1);
      if (!full) cnt_nxt = cnt_r + CW'(1);
      sum_nxt = sum_r + SW'(speed) - (full ? SW'(rd_data_r) : SW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_data_r <= mem[ptr_r];
    if (cmd.upd) mem[ptr_r] <= speed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign sum = NUM_W'(sum_r);

endmodule

FILE: rtl/motor_speed_pi_controller.sv
// ----------------------------------------------------------------------------
// motor_speed_pi_controller: PI speed loop with moving-average filter
// Converts an encoder period to speed, averages it and drives a PWM duty.
// ----------------------------------------------------------------------------
// One word in gives one word out. An accepted word has its period to speed
// division run in a divider that yields one quotient bit per cycle, 30
// quotient bits in all, and then reports done; eight steps follow for the
// window update, the average, the error and integral, the control
// numerator, the control rounding, the duty numerator, the duty scaling
// and the output load into the output register. The fixed divisions
// (window average, control rounding, duty scaling) use reciprocal
// multiplication. A zero period skips the divider, and a saturated duty
// skips the scaling step. The next word is taken in the cycle after the
// output load; no new word is taken while one is in flight. The speed
// history lives in a small synchronous memory used as a circular buffer;
// the oldest sample is read when a word is accepted and overwritten once
// the new speed is known, so the running sum is kept without a sweep.
// Entries not yet written count as zero through a fill count. A finished
// result waits in the output register, and a new word may already be taken
// while it waits; the following result then waits for the register to be
// freed. Configuration is to be written only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module motor_speed_pi_controller #(
  parameter int unsigned WINDOW = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_period_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_duty_q8,
  output logic [23:0] out_speed_avg_q8,
  output logic        out_held
);
  import spdc_pkg::*;

  // The average divides by WINDOW through a reciprocal wide enough to be
  // exact for every sum the window can hold.
  localparam int unsigned AVG_C  = $clog2(WINDOW);
  localparam int unsigned AVG_K  = 24 + 2 * AVG_C;
  localparam int unsigned AVG_MW = 25 + AVG_C;
  localparam int unsigned AVG_PW = NUM_W + AVG_MW;
  localparam logic [AVG_MW-1:0] AVG_RCP =
    AVG_MW'(((64'd1 << AVG_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  spdc_state_t state_r, state_nxt;
  spdc_win_cmd_t win_cmd;

  logic [6:0] target_r;
  logic       reverse_r, hold_r;

  logic [23:0] speed_r, speed_nxt;
  logic [23:0] avg_r, avg_nxt;
  logic signed [24:0] integ_r, integ_nxt;
  logic signed [25:0] prev_r, prev_nxt;
  logic signed [36:0] prod_r, prod_nxt;
  logic               neg_r, neg_nxt;
  logic [25:0] un_r, un_nxt;
  logic [6:0]  uq_r, uq_nxt;
  logic [21:0] dnum_r, dnum_nxt;
  logic [14:0] duty_r, duty_nxt;

  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [DEN_W-1:0]  div_den;
  logic [NUM_W-1:0]  win_sum;

  logic [NUM_W-1:0]   avg_num;
  logic [AVG_PW-1:0]  avg_prod;
  logic [34:0]        uq_prod;
  logic [44:0]        duty_prod;

  logic signed [25:0] err;
  logic signed [26:0] acc, acc_c;
  logic signed [37:0] unum;
  logic [37:0]        umag, umag_c;
  logic signed [9:0]  xval, usig;

  logic        out_valid_r, out_valid_nxt;
  logic [14:0] out_duty_r, out_duty_nxt;
  logic [23:0] out_avg_r, out_avg_nxt;
  logic        out_held_r, out_held_nxt;
  logic        held;

  // Configuration registers; index values beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= 7'd42;
      reverse_r <= 1'b0;
      hold_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET:  target_r  <= cfg_wdata;
        REG_REVERSE: reverse_r <= cfg_wdata[0];
        REG_HOLD:    hold_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  spdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  spdc_window #(.WINDOW(WINDOW)) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (win_cmd),
    .speed (speed_r),
    .sum   (win_sum)
  );

  assign held = hold_r || (target_r < TGT_LOW) || (target_r > TGT_HIGH);

  // Rounded average: half the window is added before the reciprocal multiply.
  assign avg_num  = win_sum + NUM_W'(WINDOW / 2);
  assign avg_prod = AVG_PW'(avg_num) * AVG_PW'(AVG_RCP);

  // Error and integral: trapezoidal update held in scaled units, then clamped.
  assign err  = $signed({1'b0, target_r, 8'd0, 10'd0} >> 10) - $signed({2'b00, avg_r});
  assign acc  = 27'(integ_r) + 27'(prev_r) + 27'(err);
  assign acc_c = (acc > INT_LIMIT) ? INT_LIMIT : ((acc < -INT_LIMIT) ? -INT_LIMIT : acc);

  // Control numerator; its magnitude is capped where the duty saturates anyway.
  assign unum   = 38'(prod_r) + (38'(integ_r) <<< 1);
  assign umag   = unum[37] ? 38'(-unum) : 38'(unum);
  assign umag_c = (umag > U_MAG_LIM) ? U_MAG_LIM : umag;

  // Rounded magnitude over 320000: drop nine bits, then divide by 625.
  assign uq_prod   = 35'(un_r[25:9]) * 35'(U_RCP);
  assign duty_prod = 45'(dnum_r) * 45'(DUTY_RCP);

  assign usig = (neg_r ^ reverse_r) ? -$signed({3'b000, uq_r})
                                    : $signed({3'b000, uq_r});
  assign xval = 10'sd79 + usig;

  always_comb begin
    state_nxt     = state_r;
    win_cmd       = '0;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    speed_nxt     = speed_r;
    avg_nxt       = avg_r;
    integ_nxt     = integ_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    un_nxt        = un_r;
    uq_nxt        = uq_r;
    dnum_nxt      = dnum_r;
    duty_nxt      = duty_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_duty_nxt  = out_duty_r;
    out_avg_nxt   = out_avg_r;
    out_held_nxt  = out_held_r;
    in_stall      = (state_r != ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          win_cmd.rd = 1'b1;
          if (in_period_count == 16'd0) begin
            speed_nxt = SPEED_MAX;
            state_nxt = ST_SUM;
          end else begin
            div_start = 1'b1;
            div_num   = NUM_W'(SPEED_NUM) + NUM_W'(in_period_count) * NUM_W'(7);
            div_den   = DEN_W'(in_period_count) * DEN_W'(14);
            state_nxt = ST_SPD;
          end
        end
      end
      ST_SPD: begin
        if (div_done) begin
          speed_nxt = (div_quo > NUM_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[23:0];
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        win_cmd.upd = 1'b1;
        state_nxt   = ST_AVG;
      end
      ST_AVG: begin
        avg_nxt   = avg_prod[AVG_K +: 24];
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        integ_nxt = 25'(acc_c);
        prev_nxt  = err;
        prod_nxt  = 37'($signed({1'b0, KP_GAIN})) * 37'(err);
        state_nxt = ST_UST;
      end
      ST_UST: begin
        neg_nxt   = unum[37];
        un_nxt    = 26'(umag_c) + 26'(U_HALF);
        state_nxt = ST_UQ;
      end
      ST_UQ: begin
        uq_nxt    = uq_prod[27 +: 7];
        state_nxt = ST_DNUM;
      end
      ST_DNUM: begin
        if (xval <= 10'sd0) begin
          duty_nxt  = DUTY_ZERO;
          state_nxt = ST_FIN;
        end else if (xval >= 10'sd158) begin
          duty_nxt  = DUTY_FULL;
          state_nxt = ST_FIN;
        end else begin
          dnum_nxt  = 22'(xval[7:0]) * 22'd25600 + 22'd79;
          state_nxt = ST_DSCL;
        end
      end
      ST_DSCL: begin
        duty_nxt  = duty_prod[30 +: 15];
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_duty_nxt  = held ? DUTY_HALF : duty_r;
          out_avg_nxt   = avg_r;
          out_held_nxt  = held;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      integ_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    speed_r    <= speed_nxt;
    avg_r      <= avg_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    un_r       <= un_nxt;
    uq_r       <= uq_nxt;
    dnum_r     <= dnum_nxt;
    duty_r     <= duty_nxt;
    out_duty_r <= out_duty_nxt;
    out_avg_r  <= out_avg_nxt;
    out_held_r <= out_held_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_duty_q8      = out_duty_r;
  assign out_speed_avg_q8 = out_avg_r;
  assign out_held         = out_held_r;

  // The duty never leaves its 0 to 100 percent range.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_q8 <= DUTY_FULL)
    else $error("duty above full scale");

  // A held word always carries fifty percent duty.
  a_held_half: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_held) |-> out_duty_q8 == DUTY_HALF)
    else $error("held word without half duty");

  // Once a word is taken the sequencer stops accepting until it finishes.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while busy");

endmodule
